>>> design/flv_stream_tag_parser_unit_assert.svh
// Assertion macros for the FLV tag parser.
// Used by the top level; expects aclk and aresetn in the including scope.
`ifndef FLV_STREAM_TAG_PARSER_UNIT_ASSERT_SVH
`define FLV_STREAM_TAG_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FSP_ASSERT_SAME(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSP_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> design/fsp_pkg.sv
// Shared types and constants for the FLV tag parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fsp_pkg;

    localparam int POSITION_BITS_DEF = 32;
    localparam int QUEUE_DEPTH_DEF   = 4;
    localparam int COUNT_BITS        = 24;
    localparam int OFFSET_BITS       = 32;
    localparam int TDATA_BITS        = 168;
    localparam int TUSER_BITS        = 3;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_PREV,
        PH_TAG,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        REC_HEADER,
        REC_BAD_SIG,
        REC_TAG
    } rec_class_t;

    typedef enum logic [2:0] {
        KIND_HEADER   = 3'd0,
        KIND_AUDIO    = 3'd1,
        KIND_VIDEO    = 3'd2,
        KIND_SCRIPT   = 3'd3,
        KIND_BAD_SIG  = 3'd4,
        KIND_BAD_TYPE = 3'd5
    } record_kind_t;

    localparam logic [4:0] TAG_AUDIO  = 5'd8;
    localparam logic [4:0] TAG_VIDEO  = 5'd9;
    localparam logic [4:0] TAG_SCRIPT = 5'd18;

    localparam logic [3:0] CODEC_AVC  = 4'd7;
    localparam logic [3:0] FORMAT_AAC = 4'd10;
    localparam logic [3:0] FRAME_INFO = 4'd5;

    localparam logic [2:0] NEED_AUDIO = 3'd2;
    localparam logic [2:0] NEED_VIDEO = 3'd6;

    localparam logic [7:0] SIG_UP_F = 8'h46;
    localparam logic [7:0] SIG_UP_L = 8'h4c;
    localparam logic [7:0] SIG_UP_V = 8'h56;
    localparam logic [7:0] SIG_LO_F = 8'h66;
    localparam logic [7:0] SIG_LO_L = 8'h6c;
    localparam logic [7:0] SIG_LO_V = 8'h76;

    // Raw capture handed from the parser to the decode stage.
    typedef struct packed {
        rec_class_t  rec_class;
        logic [31:0] tag_offset;
        logic [31:0] lead;     // signature+version, or tag type and size
        logic [55:0] hdr;      // header bytes from byte 4 on
        logic [47:0] pay;      // first six payload bytes, byte 0 on top
    } entry_t;

    typedef struct packed {
        phase_t phase;
        logic   halted;
    } front_status_t;

    typedef struct packed {
        record_kind_t record_kind;
        logic [31:0]  tag_offset;
        logic [23:0]  size_value;
        logic [23:0]  timestamp;
        logic [7:0]   timestamp_ext;
        logic [23:0]  stream_id;
        logic         filter_bit;
        logic [3:0]   codec_or_format;
        logic [3:0]   mode_bits;
        logic [7:0]   packet_type;
        logic [23:0]  cts_offset;
        logic [7:0]   video_info;
    } record_t;

endpackage

>>> design/fsp_front.sv
// Byte parser: tracks header/prev-size/tag/payload phases and captures fields.
// Depends on fsp_pkg; pushes one raw capture per finished record.
`timescale 1ns / 1ps

module fsp_front #(
    parameter int POSITION_BITS = fsp_pkg::POSITION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            data_byte,
    input  logic                  first_byte,
    output logic                  push,
    output fsp_pkg::entry_t       push_entry,
    output fsp_pkg::front_status_t status
);
    import fsp_pkg::*;

    localparam int POS_EXT = (POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS;

    phase_t                   phase_reg, phase_next, cur_phase;
    logic [COUNT_BITS-1:0]    count_reg, count_next, cur_count, count_inc;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, cur_pos;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [31:0]              lead_reg, lead_next, cur_lead;
    logic [55:0]              hdr_reg, hdr_next, cur_hdr;
    logic [47:0]              pay_reg, pay_next, cur_pay;
    logic                     halted_reg, halted_next;
    logic [POS_EXT-1:0]       start_ext;
    logic [4:0]               ttype;
    logic [23:0]              tsize;
    logic [2:0]               need;
    logic [COUNT_BITS-1:0]    lim;
    logic                     sig_ok;
    rec_class_t               push_class;

    // A restart mark makes this byte header byte 0 of a fresh state.
    assign cur_phase = first_byte ? PH_HEAD : phase_reg;
    assign cur_count = first_byte ? '0 : count_reg;
    assign cur_pos   = first_byte ? '0 : pos_reg;
    assign cur_lead  = first_byte ? '0 : lead_reg;
    assign cur_hdr   = first_byte ? '0 : hdr_reg;
    assign cur_pay   = first_byte ? '0 : pay_reg;
    assign count_inc = cur_count + COUNT_BITS'(1);

    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        lead_next   = lead_reg;
        hdr_next    = hdr_reg;
        pay_next    = pay_reg;
        halted_next = halted_reg;
        push        = 1'b0;
        push_class  = REC_TAG;
        ttype  = '0;
        tsize  = '0;
        need   = '0;
        lim    = '0;
        sig_ok = 1'b0;
        if (accept && (first_byte || !halted_reg)) begin
            phase_next  = cur_phase;
            count_next  = count_inc;
            pos_next    = cur_pos + POSITION_BITS'(1);
            start_next  = first_byte ? '0 : start_reg;
            lead_next   = cur_lead;
            hdr_next    = cur_hdr;
            pay_next    = cur_pay;
            halted_next = 1'b0;
            case (cur_phase)
                PH_HEAD: begin
                    if (cur_count < COUNT_BITS'(4)) begin
                        lead_next = {cur_lead[23:0], data_byte};
                    end else begin
                        hdr_next = {cur_hdr[47:0], data_byte};
                    end
                    if (cur_count == COUNT_BITS'(8)) begin
                        sig_ok = (lead_next[31:24] == SIG_UP_F && lead_next[23:16] == SIG_UP_L
                                  && lead_next[15:8] == SIG_UP_V)
                              || (lead_next[31:24] == SIG_LO_F && lead_next[23:16] == SIG_LO_L
                                  && lead_next[15:8] == SIG_LO_V);
                        push = 1'b1;
                        if (sig_ok) begin
                            push_class = REC_HEADER;
                            phase_next = PH_PREV;
                            count_next = '0;
                        end else begin
                            push_class  = REC_BAD_SIG;
                            halted_next = 1'b1;
                        end
                    end
                end
                PH_PREV: begin
                    if (cur_count >= COUNT_BITS'(3)) begin
                        phase_next = PH_TAG;
                        count_next = '0;
                    end
                end
                PH_TAG: begin
                    if (cur_count == '0) begin
                        start_next = cur_pos;
                        lead_next  = '0;
                        hdr_next   = '0;
                    end
                    if (cur_count < COUNT_BITS'(4)) begin
                        lead_next = {lead_next[23:0], data_byte};
                    end else begin
                        hdr_next = {hdr_next[47:0], data_byte};
                    end
                    if (cur_count == COUNT_BITS'(10)) begin
                        pay_next   = '0;
                        count_next = '0;
                        ttype = lead_next[28:24];
                        tsize = lead_next[23:0];
                        if (ttype != TAG_AUDIO && ttype != TAG_VIDEO && ttype != TAG_SCRIPT) begin
                            halted_next = 1'b1;
                            push = 1'b1;
                        end else begin
                            phase_next = (tsize == '0) ? PH_PREV : PH_DATA;
                            push = (ttype == TAG_SCRIPT) || (tsize == '0);
                        end
                    end
                end
                PH_DATA: begin
                    ttype = cur_lead[28:24];
                    tsize = cur_lead[23:0];
                    need  = (ttype == TAG_AUDIO) ? NEED_AUDIO :
                            (ttype == TAG_VIDEO) ? NEED_VIDEO : 3'd0;
                    if (cur_count < COUNT_BITS'(need)) begin
                        case (cur_count[2:0])
                            3'd0:    pay_next[47:40] = data_byte;
                            3'd1:    pay_next[39:32] = data_byte;
                            3'd2:    pay_next[31:24] = data_byte;
                            3'd3:    pay_next[23:16] = data_byte;
                            3'd4:    pay_next[15:8]  = data_byte;
                            3'd5:    pay_next[7:0]   = data_byte;
                            default: pay_next = cur_pay;
                        endcase
                    end
                    if (count_inc >= tsize) begin
                        phase_next = PH_PREV;
                        count_next = '0;
                    end
                    lim  = (tsize < COUNT_BITS'(need)) ? tsize : COUNT_BITS'(need);
                    push = (need != 3'd0) && (count_inc == lim);
                end
                default: begin
                    halted_next = 1'b1;
                end
            endcase
        end
    end

    assign start_ext             = POS_EXT'(start_next);
    assign push_entry.rec_class  = push_class;
    assign push_entry.tag_offset = start_ext[OFFSET_BITS-1:0];
    assign push_entry.lead       = lead_next;
    assign push_entry.hdr        = hdr_next;
    assign push_entry.pay        = pay_next;
    assign status.phase          = phase_reg;
    assign status.halted         = halted_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEAD;
            count_reg  <= '0;
            pos_reg    <= '0;
            start_reg  <= '0;
            lead_reg   <= '0;
            hdr_reg    <= '0;
            pay_reg    <= '0;
            halted_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            lead_reg   <= lead_next;
            hdr_reg    <= hdr_next;
            pay_reg    <= pay_next;
            halted_reg <= halted_next;
        end
    end

endmodule

>>> design/fsp_queue.sv
// Small FIFO of raw captures between the parser and the decode stage.
// Depends on fsp_pkg for the entry type.
`timescale 1ns / 1ps

module fsp_queue #(
    parameter int  DEPTH      = fsp_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LEVEL_BITS = $clog2(DEPTH + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  fsp_pkg::entry_t       wr_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output fsp_pkg::entry_t       rd_entry,
    output logic [LEVEL_BITS-1:0] level
);
    import fsp_pkg::*;

    entry_t                mem [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;

    assign full     = (level_reg == LEVEL_BITS'(DEPTH));
    assign empty    = (level_reg == '0);
    assign level    = level_reg;
    assign rd_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        level_next = level_reg + LEVEL_BITS'(push) - LEVEL_BITS'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

>>> design/fsp_back.sv
// Decode stage: turns a raw capture into a record and holds it in the output register.
// Depends on fsp_pkg.
`timescale 1ns / 1ps

module fsp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  fsp_pkg::entry_t   head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output fsp_pkg::record_t  out_record
);
    import fsp_pkg::*;

    record_t     rec_d;
    record_t     rec_reg;
    logic        valid_reg, valid_next;
    logic [4:0]  ttype;
    logic [7:0]  pay0, pay1, pay5;

    assign ttype = head.lead[28:24];
    assign pay0  = head.pay[47:40];
    assign pay1  = head.pay[39:32];
    assign pay5  = head.pay[7:0];

    always_comb begin
        rec_d = '0;
        case (head.rec_class)
            REC_HEADER: begin
                rec_d.record_kind = KIND_HEADER;
                rec_d.size_value  = head.hdr[23:0];
                rec_d.mode_bits   = {2'b00, head.hdr[34], head.hdr[32]};
                rec_d.packet_type = head.lead[7:0];
            end
            REC_BAD_SIG: begin
                rec_d.record_kind = KIND_BAD_SIG;
            end
            REC_TAG: begin
                rec_d.tag_offset    = head.tag_offset;
                rec_d.size_value    = head.lead[23:0];
                rec_d.timestamp     = head.hdr[55:32];
                rec_d.timestamp_ext = head.hdr[31:24];
                rec_d.stream_id     = head.hdr[23:0];
                rec_d.filter_bit    = head.lead[29];
                if (ttype == TAG_AUDIO) begin
                    rec_d.record_kind     = KIND_AUDIO;
                    rec_d.codec_or_format = pay0[7:4];
                    rec_d.mode_bits       = pay0[3:0];
                    if (pay0[7:4] == FORMAT_AAC) begin
                        rec_d.packet_type = pay1;
                    end
                end else if (ttype == TAG_VIDEO) begin
                    rec_d.record_kind     = KIND_VIDEO;
                    rec_d.codec_or_format = pay0[3:0];
                    rec_d.mode_bits       = pay0[7:4];
                    if (pay0[3:0] == CODEC_AVC) begin
                        rec_d.packet_type = pay1;
                        rec_d.cts_offset  = head.pay[31:8];
                    end
                    if (pay0[7:4] == FRAME_INFO) begin
                        rec_d.video_info = pay5;
                    end
                end else if (ttype == TAG_SCRIPT) begin
                    rec_d.record_kind = KIND_SCRIPT;
                end else begin
                    rec_d.record_kind = KIND_BAD_TYPE;
                end
            end
            default: begin
                rec_d = '0;
            end
        endcase
    end

    // Load whenever the register is empty or being drained.
    assign pop        = !q_empty && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_record = rec_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg <= rec_d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

>>> design/flv_stream_tag_parser_unit.sv
// FLV tag parser top level: stream ports, parser, record queue and decode stage.
// Depends on fsp_pkg, fsp_front, fsp_queue, fsp_back and the assertion macro header.
`timescale 1ns / 1ps

// One FLV byte per transaction on the s_ side, one record per transaction on the
// m_ side. The parser takes a byte every cycle; a record comes out for the file
// header (on header byte 8), for each tag, and for a bad signature or unknown
// tag type, after which bytes are dropped until one arrives with s_tuser set.
// s_tready only falls when the QUEUE_DEPTH-entry record queue is full, which
// happens only while the m_ side stalls: a record costs one queue write, the
// decode stage drains one entry per cycle into the output register, so the
// sustained rate is one byte per clock. The record a byte completes reaches
// m_tvalid through the queue write, then the output register load. The byte
// position counter is POSITION_BITS wide and wraps; tag offsets carry its low
// 32 bits. Fields that mean nothing for a record kind read as zero.
module flv_stream_tag_parser_unit #(
    parameter int POSITION_BITS = fsp_pkg::POSITION_BITS_DEF,
    parameter int QUEUE_DEPTH   = fsp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic                             s_tuser,   // first_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] tag_offset, [55:32] size_value, [79:56] timestamp,
    // [87:80] timestamp_ext, [111:88] stream_id, [112] filter_bit,
    // [116:113] codec_or_format, [120:117] mode_bits, [128:121] packet_type,
    // [152:129] cts_offset, [160:153] video_info, [167:161] zero
    output logic [fsp_pkg::TDATA_BITS-1:0]  m_tdata,
    output logic [fsp_pkg::TUSER_BITS-1:0]  m_tuser    // [2:0] record_kind
);
    import fsp_pkg::*;

    localparam int LEVEL_BITS = $clog2(QUEUE_DEPTH + 1);

    logic                  s_accept;
    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    logic [LEVEL_BITS-1:0] q_level;
    entry_t                q_wr_entry;
    entry_t                q_rd_entry;
    front_status_t         front_status;
    record_t               out_record;
    logic                  halt_idle;
    logic                  hdr_push;

    // Input transaction: the parser never stalls, only the queue can.
    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    fsp_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .data_byte  (s_tdata),
        .first_byte (s_tuser),
        .push       (q_push),
        .push_entry (q_wr_entry),
        .status     (front_status)
    );

    // Raw captures wait here so the parser keeps running while m_ stalls.
    fsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .rd_entry (q_rd_entry),
        .level    (q_level)
    );

    fsp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .head       (q_rd_entry),
        .pop        (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_record (out_record)
    );

    // Pack the record, first field lowest; the kind travels on tuser.
    assign m_tuser = out_record.record_kind;
    assign m_tdata = {7'd0,
                      out_record.video_info,
                      out_record.cts_offset,
                      out_record.packet_type,
                      out_record.mode_bits,
                      out_record.codec_or_format,
                      out_record.filter_bit,
                      out_record.stream_id,
                      out_record.timestamp_ext,
                      out_record.timestamp,
                      out_record.size_value,
                      out_record.tag_offset};

    // Conditions watched by the assertions below.
    assign halt_idle = front_status.halted && !s_tuser;
    assign hdr_push  = q_push && (q_wr_entry.rec_class == REC_HEADER);

    `include "flv_stream_tag_parser_unit_assert.svh"

    // A halted parser must not produce records until a restart mark.
    `FSP_ASSERT_SAME(a_halt_silent, halt_idle, !q_push, "record pushed while halted")
    // A good file header always moves the parser on to the previous-tag size.
    `FSP_ASSERT_NEXT(a_header_phase, hdr_push, front_status.phase == PH_PREV, "no phase change")
    // Queue occupancy stays within its depth.
    `FSP_ASSERT_SAME(a_queue_bound, 1'b1, q_level <= LEVEL_BITS'(QUEUE_DEPTH), "queue overflow")

endmodule

>>> verif/flv_stream_tag_parser_unit_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the FLV tag parser: tracks the parse of every accepted byte,
// predicts the records it causes and compares them with the m_ side.
// Depends on fsp_pkg.
module flv_stream_tag_parser_unit_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [fsp_pkg::TDATA_BITS-1:0] m_tdata,
    input  logic [fsp_pkg::TUSER_BITS-1:0] m_tuser,
    output int                            fail_count,
    output int                            pending_count
);

    import fsp_pkg::*;

    // parser state as seen by the prediction
    phase_t      phase;
    logic [23:0] count;
    logic [31:0] position;
    logic [31:0] tag_at;
    logic [31:0] lead;
    logic [63:0] hdr;
    logic [47:0] pay;
    logic        halted;

    record_t expected_records[$];
    int      mismatches = 0;

    task automatic reset_parser();
        phase    = PH_HEAD;
        count    = '0;
        position = '0;
        tag_at   = '0;
        lead     = '0;
        hdr      = '0;
        pay      = '0;
        halted   = 1'b0;
    endtask

    function automatic record_t tag_record();
        record_t    rec;
        logic [4:0] ty;
        ty  = lead[28:24];
        rec = '0;
        case (ty)
            TAG_AUDIO:  rec.record_kind = KIND_AUDIO;
            TAG_VIDEO:  rec.record_kind = KIND_VIDEO;
            TAG_SCRIPT: rec.record_kind = KIND_SCRIPT;
            default:    rec.record_kind = KIND_BAD_TYPE;
        endcase
        rec.tag_offset    = tag_at;
        rec.size_value    = lead[23:0];
        rec.timestamp     = hdr[55:32];
        rec.timestamp_ext = hdr[31:24];
        rec.stream_id     = hdr[23:0];
        rec.filter_bit    = lead[29];
        if (ty == TAG_AUDIO) begin
            rec.codec_or_format = pay[47:44];
            rec.mode_bits       = pay[43:40];
            if (pay[47:44] == FORMAT_AAC) rec.packet_type = pay[39:32];
        end else if (ty == TAG_VIDEO) begin
            rec.codec_or_format = pay[43:40];
            rec.mode_bits       = pay[47:44];
            if (pay[43:40] == CODEC_AVC) begin
                rec.packet_type = pay[39:32];
                rec.cts_offset  = pay[31:8];
            end
            if (pay[47:44] == FRAME_INFO) rec.video_info = pay[7:0];
        end
        return rec;
    endfunction

    task automatic parse_byte(input logic [7:0] b, input logic is_first);
        logic [31:0] at;
        logic [4:0]  ty;
        int          c;
        int          sz;
        int          need;
        int          lim;
        record_t     rec;
        if (is_first) reset_parser();
        else if (halted) return;
        at       = position;
        position = position + 32'd1;
        c        = int'(count);
        case (phase)
            PH_HEAD: begin
                if (c < 4) lead = {lead[23:0], b};
                else hdr = {hdr[55:0], b};
                count = 24'(c + 1);
                if (c == 8) begin
                    rec = '0;
                    if (lead[31:8] != {SIG_UP_F, SIG_UP_L, SIG_UP_V} &&
                        lead[31:8] != {SIG_LO_F, SIG_LO_L, SIG_LO_V}) begin
                        rec.record_kind = KIND_BAD_SIG;
                        halted = 1'b1;
                    end else begin
                        rec.record_kind = KIND_HEADER;
                        rec.size_value  = hdr[23:0];
                        rec.mode_bits   = {2'b00, hdr[34], hdr[32]};
                        rec.packet_type = lead[7:0];
                        phase = PH_PREV;
                        count = '0;
                    end
                    expected_records.push_back(rec);
                end
            end
            PH_PREV: begin
                count = 24'(c + 1);
                if (c + 1 >= 4) begin
                    phase = PH_TAG;
                    count = '0;
                end
            end
            PH_TAG: begin
                if (c == 0) begin
                    tag_at = at;
                    lead   = '0;
                    hdr    = '0;
                end
                if (c < 4) lead = {lead[23:0], b};
                else hdr = {hdr[55:0], b};
                count = 24'(c + 1);
                if (c + 1 == 11) begin
                    pay   = '0;
                    count = '0;
                    ty    = lead[28:24];
                    sz    = int'(lead[23:0]);
                    if (ty != TAG_AUDIO && ty != TAG_VIDEO && ty != TAG_SCRIPT) begin
                        halted = 1'b1;
                        expected_records.push_back(tag_record());
                    end else begin
                        phase = (sz == 0) ? PH_PREV : PH_DATA;
                        if (ty == TAG_SCRIPT || sz == 0) expected_records.push_back(tag_record());
                    end
                end
            end
            PH_DATA: begin
                ty   = lead[28:24];
                sz   = int'(lead[23:0]);
                need = (ty == TAG_AUDIO) ? int'(NEED_AUDIO) :
                       (ty == TAG_VIDEO) ? int'(NEED_VIDEO) : 0;
                if (c < need) pay = pay | (48'(b) << (40 - 8 * c));
                count = 24'(c + 1);
                // bytes past a short payload read as zero
                lim = (sz < need) ? sz : need;
                if (c + 1 >= sz) begin
                    phase = PH_PREV;
                    count = '0;
                end
                if (need != 0 && c + 1 == lim) expected_records.push_back(tag_record());
            end
            default: halted = 1'b1;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_record(input logic [TDATA_BITS-1:0] d,
                                input logic [TUSER_BITS-1:0] kind);
        record_t want;
        if (expected_records.size() == 0) begin
            $error("record of kind %0d with none predicted", kind);
            mismatches++;
            return;
        end
        want = expected_records.pop_front();
        check_field("record_kind", 32'(want.record_kind), 32'(kind));
        check_field("tag_offset", want.tag_offset, d[31:0]);
        check_field("size_value", 32'(want.size_value), 32'(d[55:32]));
        check_field("timestamp", 32'(want.timestamp), 32'(d[79:56]));
        check_field("timestamp_ext", 32'(want.timestamp_ext), 32'(d[87:80]));
        check_field("stream_id", 32'(want.stream_id), 32'(d[111:88]));
        check_field("filter_bit", 32'(want.filter_bit), 32'(d[112]));
        check_field("codec_or_format", 32'(want.codec_or_format), 32'(d[116:113]));
        check_field("mode_bits", 32'(want.mode_bits), 32'(d[120:117]));
        check_field("packet_type", 32'(want.packet_type), 32'(d[128:121]));
        check_field("cts_offset", 32'(want.cts_offset), 32'(d[152:129]));
        check_field("video_info", 32'(want.video_info), 32'(d[160:153]));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            reset_parser();
        end else begin
            if (s_tvalid && s_tready) parse_byte(s_tdata, s_tuser);
            if (m_tvalid && m_tready) check_record(m_tdata, m_tuser);
        end
        pending_count <= expected_records.size();
        fail_count    <= mismatches;
    end

endmodule

>>> verif/flv_stream_tag_parser_unit_tb.sv
`timescale 1ns / 1ps
// Top of the FLV tag parser bench: clock, reset, byte stimulus and verdict.
// Depends on fsp_pkg, flv_stream_tag_parser_unit and the scoreboard module.
module flv_stream_tag_parser_unit_tb;

    import fsp_pkg::*;

    localparam int HOLD_CYCLES  = 300;      // long m_ side stall to fill the record queue
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 10;       // queue write and output register load, plus margin
    localparam int FULL_FILE    = 1 << 30;  // byte budget that never truncates
    localparam logic [7:0] CASE_BIT = 8'h20;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // [7:0] data_byte
    logic                  s_tuser;   // first_byte
    logic                  m_tvalid;
    logic                  m_tready;
    logic [TDATA_BITS-1:0] m_tdata;   // record fields, tag_offset in the low bits
    logic [TUSER_BITS-1:0] m_tuser;   // [2:0] record_kind

    int fail_count;
    int pending_count;
    int tx_idle_pct  = 17;
    int rx_idle_pct  = 63;
    int hold_asks    = 0;
    int hold_served  = 0;
    int random_items = 0;
    int cut_left     = FULL_FILE;
    int cycle_count  = 0;

    flv_stream_tag_parser_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    flv_stream_tag_parser_unit_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run guard: a hung handshake or a record that never shows up ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("flv_stream_tag_parser_unit verification failed");
            $finish;
        end
    end

    // Record sink. Normally stalls at random; when the stimulus asks for a hold,
    // m_tready stays low for HOLD_CYCLES so the queue fills and s_tready drops.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_asks != hold_served) begin
                m_tready <= 1'b0;
                hold_served++;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one byte as a transaction and wait for it to be taken. Bytes past the
    // current file's budget (cut_left) are dropped, which truncates the file.
    // Only bytes offered with counted set add to the random total.
    task automatic put(input logic [7:0] d, input logic is_first, input logic counted);
        if (cut_left == 0) return;
        cut_left--;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= is_first;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (counted) random_items++;
    endtask

    // Payload byte 0 is biased toward the codes that unlock extra fields:
    // AAC for audio, AVC and the video-info frame type for video.
    function automatic logic [7:0] payload_byte(input logic [4:0] ty, input int k);
        logic [3:0] hi;
        logic [3:0] lo;
        hi = 4'($urandom);
        lo = 4'($urandom);
        if (k == 0 && ty == TAG_AUDIO && $urandom_range(1) == 1) hi = FORMAT_AAC;
        if (k == 0 && ty == TAG_VIDEO) begin
            if ($urandom_range(1) == 1) hi = FRAME_INFO;
            if ($urandom_range(1) == 1) lo = CODEC_AVC;
        end
        return {hi, lo};
    endfunction

    // Previous-tag size, 11-byte tag header and payload. Mostly audio, video
    // and script tags; a few random types, which halt the parser when unknown.
    task automatic send_tag(output bit bad_type);
        logic [4:0] ty;
        int         pick;
        int         sz;
        int         k;
        pick = $urandom_range(99);
        if (pick < 35) ty = TAG_AUDIO;
        else if (pick < 70) ty = TAG_VIDEO;
        else if (pick < 90) ty = TAG_SCRIPT;
        else ty = 5'($urandom);
        // zero size, short payloads (1 to 7 bytes, around the decoded bytes), medium, rare long
        pick = $urandom_range(99);
        if (pick < 30) sz = 0;
        else if (pick < 70) sz = $urandom_range(7, 1);
        else if (pick < 95) sz = $urandom_range(40, 8);
        else sz = $urandom_range(300, 41);
        repeat (4) put(8'($urandom), 1'b0, 1'b1);
        put({3'($urandom), ty}, 1'b0, 1'b1);
        put(8'h00, 1'b0, 1'b1);
        put(8'(sz >> 8), 1'b0, 1'b1);
        put(8'(sz), 1'b0, 1'b1);
        repeat (7) put(8'($urandom), 1'b0, 1'b1);
        bad_type = (ty != TAG_AUDIO && ty != TAG_VIDEO && ty != TAG_SCRIPT);
        if (!bad_type) begin
            for (k = 0; k < sz; k++) put(payload_byte(ty, k), 1'b0, 1'b1);
        end
    endtask

    // One file: header with either signature case, then a few tags. Some files
    // are cut short, some carry a broken signature, and a few start without the
    // restart mark so the parser keeps going from wherever it stood.
    task automatic send_file();
        logic [7:0] s0;
        logic [7:0] s1;
        logic [7:0] s2;
        int         pick;
        int         ntags;
        bit         bad;
        cut_left = ($urandom_range(99) < 12) ? $urandom_range(60, 1) : FULL_FILE;
        if ($urandom_range(1) == 1) {s0, s1, s2} = {SIG_UP_F, SIG_UP_L, SIG_UP_V};
        else {s0, s1, s2} = {SIG_LO_F, SIG_LO_L, SIG_LO_V};
        pick = $urandom_range(99);
        if (pick < 8) begin
            case ($urandom_range(3))
                0:       s0 = s0 ^ CASE_BIT;
                1:       s1 = s1 ^ CASE_BIT;
                2:       s2 = s2 ^ CASE_BIT;
                default: {s0, s1, s2} = 24'($urandom);
            endcase
        end
        bad = ({s0, s1, s2} != {SIG_UP_F, SIG_UP_L, SIG_UP_V}) &&
              ({s0, s1, s2} != {SIG_LO_F, SIG_LO_L, SIG_LO_V});
        put(s0, ($urandom_range(19) != 0), 1'b1);
        put(s1, 1'b0, 1'b1);
        put(s2, 1'b0, 1'b1);
        repeat (6) put(8'($urandom), 1'b0, 1'b1);
        ntags = $urandom_range(6, 1);
        while (!bad && ntags > 0) begin
            send_tag(bad);
            ntags--;
        end
        // after an error record the parser drops bytes until the next mark
        if (bad) repeat ($urandom_range(3)) put(8'($urandom), 1'b0, 1'b0);
    endtask

    initial begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        aresetn  = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: lower-case header right after reset with no restart mark,
        // version, flags and offset all ones.
        put(SIG_LO_F, 1'b0, 1'b0);
        put(SIG_LO_L, 1'b0, 1'b0);
        put(SIG_LO_V, 1'b0, 1'b0);
        repeat (6) put(8'hff, 1'b0, 1'b0);
        // All-ones previous size, then a tag of unknown type with filter set and
        // every header field at its maximum: error record, parser halts.
        repeat (15) put(8'hff, 1'b0, 1'b0);
        // dropped while halted
        put(SIG_UP_F, 1'b0, 1'b0);
        // restart with a mixed-case signature and zero fields: bad signature
        put(SIG_UP_F, 1'b1, 1'b0);
        put(SIG_LO_L, 1'b0, 1'b0);
        put(SIG_UP_V, 1'b0, 1'b0);
        repeat (6) put(8'h00, 1'b0, 1'b0);

        // Back-pressure: the sink holds off while a dense run of empty script
        // tags (one record per 15 bytes) keeps arriving with no gaps.
        tx_idle_pct = 0;
        hold_asks++;
        put(SIG_UP_F, 1'b1, 1'b0);
        put(SIG_UP_L, 1'b0, 1'b0);
        put(SIG_UP_V, 1'b0, 1'b0);
        repeat (6) put(8'h00, 1'b0, 1'b0);
        repeat (24) begin
            repeat (4) put(8'h00, 1'b0, 1'b0);
            put({3'b000, TAG_SCRIPT}, 1'b0, 1'b0);
            repeat (10) put(8'h00, 1'b0, 1'b0);
        end

        // Random files in three idle mixes: sparse sender gaps with a slow sink,
        // the reverse, then full rate on both sides.
        tx_idle_pct = 17;
        rx_idle_pct = 63;
        while (random_items < 520) send_file();
        tx_idle_pct = 63;
        rx_idle_pct = 17;
        while (random_items < 1040) send_file();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (random_items < 1560) send_file();
        s_tvalid <= 1'b0;

        // drain: every predicted record in, then a margin for strays
        do @(posedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("flv_stream_tag_parser_unit verification clean");
        end else begin
            $display("flv_stream_tag_parser_unit verification failed");
        end
        $finish;
    end

endmodule
